### rtl/ldf_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and stage-to-stage structs of the Lambert diffuse factor unit.
// Depends on nothing; every other file imports it.
package ldf_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int NORM_W          = 16;   // Q1.14 normal component
    localparam int MAG_W           = 16;   // light vector magnitude after scaling
    localparam int PROD_W          = 33;   // normal times signed component
    localparam int DOT_W           = 35;   // dot product
    localparam int SQ_W            = 34;   // squared length
    localparam int DMAG_W          = 34;   // positive dot product
    localparam int PP_W            = 51;   // partial product of the dot square
    localparam int REM_W           = 70;   // 4 * dot^2 and remainder
    localparam int QT_W            = 49;   // quotient times squared length
    localparam int Q_W             = 15;   // quotient bits below 1.0
    localparam int OUT_W           = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [OUT_W-1:0] ONE_Q15 = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z = 2'd2;

    // Scaled light vector with the normal riding along
    typedef struct packed {
        logic [2:0][MAG_W-1:0]  mag;
        logic [2:0]             neg;
        logic [2:0][NORM_W-1:0] normal;
        logic                   degen;
    } t_vec;

    // Dot product and squared length
    typedef struct packed {
        logic [DOT_W-1:0] dot;
        logic [SQ_W-1:0]  sq;
        logic             degen;
    } t_dot;

endpackage

### rtl/ldf_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: point item, result item and register writes.
// Depends on ldf_pkg.
interface ldf_pt_if import ldf_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF) ();
    logic                    valid;
    logic                    ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [NORM_W-1:0]      normal_x;
    logic signed [NORM_W-1:0]      normal_y;
    logic signed [NORM_W-1:0]      normal_z;
    modport source(output valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                   input ready);
    modport sink(input valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                 output ready);
endinterface

interface ldf_res_if import ldf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] diffuse_factor;
    logic             degenerate;
    modport source(output valid, diffuse_factor, degenerate, input ready);
    modport sink(input valid, diffuse_factor, degenerate, output ready);
endinterface

interface ldf_cfg_if import ldf_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF) ();
    logic                          valid;
    logic                          ready;
    logic [CFG_IDX_W-1:0]          index;
    logic signed [COORD_WIDTH-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

### rtl/ldf_vec.sv
`timescale 1ns / 1ps
// Light vector stages: subtract point from light, take magnitudes, scale into 16 bits.
// Depends on ldf_pkg.
module ldf_vec import ldf_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [2:0][COORD_WIDTH-1:0]      i_light,
    input  logic [2:0][COORD_WIDTH-1:0]      i_point,
    input  logic [2:0][NORM_W-1:0]           i_normal,
    output logic                             o_valid,
    output t_vec                             o_vec
);

    localparam int MW  = COORD_WIDTH + 1;
    localparam int EW  = (MW > MAG_W) ? MW : MAG_W;
    localparam int SHW = $clog2(EW - MAG_W + 2);

    logic [2:0][MW-1:0]     n1_mag;
    logic [2:0]             n1_neg;
    logic                   n1_degen;
    logic [2:0][MW-1:0]     r1_mag;
    logic [2:0]             r1_neg;
    logic [2:0][NORM_W-1:0] r1_normal;
    logic                   r1_degen;
    logic                   r1_valid;
    logic [EW-1:0]          ext_or;
    logic [SHW-1:0]         sh;
    t_vec                   n2_vec;
    t_vec                   r2_vec;
    logic                   r2_valid;

    // Stage 1: light minus point, sign and magnitude
    always_comb begin
        logic signed [MW-1:0] diff;
        n1_degen = 1'b1;
        for (int i = 0; i < 3; i++) begin
            diff = $signed({i_light[i][COORD_WIDTH-1], i_light[i]})
                 - $signed({i_point[i][COORD_WIDTH-1], i_point[i]});
            n1_neg[i] = diff[MW-1];
            n1_mag[i] = diff[MW-1] ? MW'(-diff) : MW'(diff);
            if (diff != '0) begin
                n1_degen = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_mag    <= n1_mag;
            r1_neg    <= n1_neg;
            r1_normal <= i_normal;
            r1_degen  <= n1_degen;
        end
    end

    // Stage 2: shift all magnitudes together until each fits 16 bits
    always_comb begin
        ext_or = EW'(r1_mag[0]) | EW'(r1_mag[1]) | EW'(r1_mag[2]);
        sh     = '0;
        for (int i = MAG_W; i < EW; i++) begin
            if (ext_or[i]) begin
                sh = SHW'(i - MAG_W + 1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            n2_vec.mag[i] = MAG_W'(EW'(r1_mag[i]) >> sh);
        end
        n2_vec.neg    = r1_neg;
        n2_vec.normal = r1_normal;
        n2_vec.degen  = r1_degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_vec <= n2_vec;
        end
    end

    assign o_valid = r2_valid;
    assign o_vec   = r2_vec;

endmodule

### rtl/ldf_dot.sv
`timescale 1ns / 1ps
// Dot product and squared length stages: products, then sums.
// Depends on ldf_pkg.
module ldf_dot import ldf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_vec i_vec,
    output logic o_valid,
    output t_dot o_dot
);

    logic signed [2:0][PROD_W-1:0] n3_prod;
    logic [2:0][2*MAG_W-1:0]       n3_sq;
    logic signed [2:0][PROD_W-1:0] r3_prod;
    logic [2:0][2*MAG_W-1:0]       r3_sq;
    logic                          r3_degen;
    logic                          r3_valid;
    t_dot                          n4_dot;
    t_dot                          r4_dot;
    logic                          r4_valid;

    // Stage 3: signed products and squares
    always_comb begin
        logic signed [MAG_W:0] comp;
        for (int i = 0; i < 3; i++) begin
            comp       = i_vec.neg[i] ? -$signed({1'b0, i_vec.mag[i]})
                                      :  $signed({1'b0, i_vec.mag[i]});
            n3_prod[i] = $signed(i_vec.normal[i]) * comp;
            n3_sq[i]   = i_vec.mag[i] * i_vec.mag[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_valid;
        end
        if (i_en) begin
            r3_prod  <= n3_prod;
            r3_sq    <= n3_sq;
            r3_degen <= i_vec.degen;
        end
    end

    // Stage 4: sum the three terms
    always_comb begin
        n4_dot.dot = DOT_W'($signed(r3_prod[0])) + DOT_W'($signed(r3_prod[1]))
                   + DOT_W'($signed(r3_prod[2]));
        n4_dot.sq  = SQ_W'(r3_sq[0]) + SQ_W'(r3_sq[1]) + SQ_W'(r3_sq[2]);
        n4_dot.degen = r3_degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
        if (i_en) begin
            r4_dot <= n4_dot;
        end
    end

    assign o_valid = r4_valid;
    assign o_dot   = r4_dot;

endmodule

### rtl/ldf_div.sv
`timescale 1ns / 1ps
// Quotient stages: square the dot product, then one quotient bit per stage of
// floor(2*dot / sqrt(sq)) with saturation at 1.0. Depends on ldf_pkg.
module ldf_div import ldf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_dot             i_dot,
    output logic             o_valid,
    output logic [OUT_W-1:0] o_factor,
    output logic             o_degen
);

    localparam int NS = Q_W + 1;

    logic [DMAG_W-1:0]   dmag;
    logic                n5_pos;
    logic [PP_W-1:0]     r5_phi;
    logic [PP_W-1:0]     r5_plo;
    logic [SQ_W-1:0]     r5_sq;
    logic                r5_pos;
    logic                r5_degen;
    logic                r5_valid;
    logic [REM_W-1:0]    r6_rem;
    logic [SQ_W-1:0]     r6_sq;
    logic                r6_pos;
    logic                r6_degen;
    logic                r6_valid;

    logic [REM_W-1:0]    r_rem   [NS];
    logic [QT_W-1:0]     r_qt    [NS];
    logic [SQ_W-1:0]     r_sq    [NS];
    logic [Q_W-1:0]      r_q     [NS];
    logic                r_sat   [NS];
    logic                r_pos   [NS];
    logic                r_degen [NS];
    logic                r_valid [NS];

    logic [OUT_W-1:0]    n_factor;
    logic [OUT_W-1:0]    r_factor;
    logic                r_odegen;
    logic                r_ovalid;

    // Stage 5: keep positive dot only, split its square into two partial products
    assign n5_pos = !i_dot.degen && ($signed(i_dot.dot) > 0);
    assign dmag   = n5_pos ? DMAG_W'(i_dot.dot) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= i_valid;
        end
        if (i_en) begin
            r5_phi   <= dmag * dmag[DMAG_W-1:17];
            r5_plo   <= dmag * dmag[16:0];
            r5_sq    <= i_dot.sq;
            r5_pos   <= n5_pos;
            r5_degen <= i_dot.degen;
        end
    end

    // Stage 6: assemble 4 * dot^2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r6_valid <= r5_valid;
        end
        if (i_en) begin
            r6_rem   <= (REM_W'(r5_phi) << 19) + (REM_W'(r5_plo) << 2);
            r6_sq    <= r5_sq;
            r6_pos   <= r5_pos;
            r6_degen <= r5_degen;
        end
    end

    // Stage 7: saturation test, clear quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= r6_valid;
        end
        if (i_en) begin
            r_rem[0]   <= r6_rem;
            r_qt[0]    <= '0;
            r_sq[0]    <= r6_sq;
            r_q[0]     <= '0;
            r_sat[0]   <= (REM_W'(r6_sq) << 30) <= r6_rem;
            r_pos[0]   <= r6_pos;
            r_degen[0] <= r6_degen;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < Q_W; j++) begin : g_bit
        localparam int K = Q_W - 1 - j;
        logic [REM_W-1:0] trial;
        logic             take;

        assign trial = (REM_W'(r_qt[j]) << (K + 1)) + (REM_W'(r_sq[j]) << (2 * K));
        assign take  = trial <= r_rem[j];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[j+1] <= r_valid[j];
            end
            if (i_en) begin
                r_rem[j+1]   <= take ? r_rem[j] - trial : r_rem[j];
                r_qt[j+1]    <= take ? r_qt[j] + (QT_W'(r_sq[j]) << K) : r_qt[j];
                r_q[j+1]     <= r_q[j] | (Q_W'(take) << K);
                r_sq[j+1]    <= r_sq[j];
                r_sat[j+1]   <= r_sat[j];
                r_pos[j+1]   <= r_pos[j];
                r_degen[j+1] <= r_degen[j];
            end
        end
    end

    // Output register: pick zero, one or the quotient
    always_comb begin
        priority if (!r_pos[NS-1]) begin
            n_factor = '0;
        end else if (r_sat[NS-1]) begin
            n_factor = ONE_Q15;
        end else begin
            n_factor = OUT_W'(r_q[NS-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_en) begin
            r_ovalid <= r_valid[NS-1];
        end
        if (i_en) begin
            r_factor <= n_factor;
            r_odegen <= r_degen[NS-1];
        end
    end

    assign o_valid  = r_ovalid;
    assign o_factor = r_factor;
    assign o_degen  = r_odegen;

endmodule

### rtl/lambert_diffuse_factor_unit.sv
`timescale 1ns / 1ps
// Lambert diffuse factor unit: a registered pipeline from an accepted point item to its result.
// Throughput one item per cycle; the whole pipeline advances whenever the output
// register is empty or taken, so a stall holds every stage in place.
// Synchronous active-low reset clears all valid bits and the light position.
// The register write channel is always ready. Depends on ldf_pkg, ldf_ifs, ldf_vec,
// ldf_dot and ldf_div.
module lambert_diffuse_factor_unit import ldf_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ldf_pt_if.sink     i_pt,
    ldf_res_if.source  o_res,
    ldf_cfg_if.sink    i_cfg
);

    logic [2:0][COORD_WIDTH-1:0] r_light;
    logic                        en;
    logic                        vec_valid;
    t_vec                        vec;
    logic                        dot_valid;
    t_dot                        dot;
    logic                        res_valid;
    logic [OUT_W-1:0]            res_factor;
    logic                        res_degen;

    // Light position registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_LIGHT_X: r_light[0] <= i_cfg.data;
                CFG_LIGHT_Y: r_light[1] <= i_cfg.data;
                CFG_LIGHT_Z: r_light[2] <= i_cfg.data;
                default:     r_light    <= r_light;
            endcase
        end
    end

    // Advance the pipeline unless a result waits untaken
    assign en         = !res_valid || o_res.ready;
    assign i_pt.ready = en;

    ldf_vec #(.COORD_WIDTH(COORD_WIDTH)) u_vec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_pt.valid),
        .i_light  (r_light),
        .i_point  ({i_pt.point_z, i_pt.point_y, i_pt.point_x}),
        .i_normal ({i_pt.normal_z, i_pt.normal_y, i_pt.normal_x}),
        .o_valid  (vec_valid),
        .o_vec    (vec)
    );

    ldf_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (vec_valid),
        .i_vec   (vec),
        .o_valid (dot_valid),
        .o_dot   (dot)
    );

    ldf_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (dot_valid),
        .i_dot    (dot),
        .o_valid  (res_valid),
        .o_factor (res_factor),
        .o_degen  (res_degen)
    );

    assign o_res.valid          = res_valid;
    assign o_res.diffuse_factor = res_factor;
    assign o_res.degenerate     = res_degen;

    // A coincident point never carries a nonzero factor
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res_degen |-> res_factor == '0)
        else $error("degenerate result with nonzero factor");

    // The factor never exceeds 1.0
    a_factor_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> res_factor <= ONE_Q15)
        else $error("factor above one");

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !res_valid)
        else $error("result valid right after reset");

    // The light vector stage's valid moves only with the pipeline enable
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> vec_valid == $past(vec_valid))
        else $error("stage valid changed during stall");

endmodule

### dv/lambert_diffuse_factor_unit_tb.sv
`timescale 1ns / 1ps
// Testbench of the Lambert diffuse factor unit: random and directed point items,
// light position writes between phases, results checked in order against a predictor.
// Depends on ldf_pkg, ldf_ifs and the unit RTL.
module lambert_diffuse_factor_unit_tb;
    import ldf_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int LATENCY = 23;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [OUT_W-1:0] factor;
        logic             degen;
    } t_shade;

    // Holds light position, predicts factors and checks arriving results in order
    class shade_board;
        logic signed [CW-1:0] light [3];
        t_shade pending [$];
        int errors;

        function void set_light(logic [CFG_IDX_W-1:0] idx, logic signed [CW-1:0] v);
            if (idx == CFG_LIGHT_X) light[0] = v;
            else if (idx == CFG_LIGHT_Y) light[1] = v;
            else if (idx == CFG_LIGHT_Z) light[2] = v;
        endfunction

        function t_shade predict(logic signed [CW-1:0] p [3], logic signed [15:0] n [3]);
            t_shade r;
            longint lv [3];
            longint unsigned m [3];
            longint unsigned s, q, lo, hi, mid;
            longint d;
            logic [127:0] d4, t;
            for (int i = 0; i < 3; i++) begin
                lv[i] = longint'(light[i]) - longint'(p[i]);
                m[i] = lv[i] < 0 ? -lv[i] : lv[i];
            end
            r.degen = (m[0] == 0 && m[1] == 0 && m[2] == 0);
            r.factor = '0;
            if (r.degen) return r;
            while (m[0] >= 65536 || m[1] >= 65536 || m[2] >= 65536) begin
                m[0] >>= 1; m[1] >>= 1; m[2] >>= 1;
            end
            s = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
            d = 0;
            for (int i = 0; i < 3; i++)
                d += longint'(n[i]) * (lv[i] < 0 ? -longint'(m[i]) : longint'(m[i]));
            if (d <= 0) return r;
            d4 = 128'(d) * 128'(d) * 4;
            t = 128'(32768) * 32768 * s;
            if (t <= d4) begin
                r.factor = ONE_Q15;
                return r;
            end
            // largest q with q*q*s <= 4*d*d
            lo = 0; hi = 32768;
            while (hi - lo > 1) begin
                mid = (lo + hi) >> 1;
                t = 128'(mid) * mid * s;
                if (t <= d4) lo = mid; else hi = mid;
            end
            q = lo;
            r.factor = q[15:0];
            return r;
        endfunction

        function void note_point(logic signed [CW-1:0] p [3], logic signed [15:0] n [3]);
            pending.push_back(predict(p, n));
        endfunction

        function void check_result(logic [OUT_W-1:0] f, logic dg);
            t_shade e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result factor=%0d degen=%0b", f, dg);
                return;
            end
            e = pending.pop_front();
            if (e.factor !== f || e.degen !== dg) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected factor=%0d degen=%0b, got factor=%0d degen=%0b",
                             e.factor, e.degen, f, dg);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    shade_board board = new();
    int idle_cycles = 0;
    bit src_quiet = 0, snk_quiet = 0;

    ldf_pt_if  #(.COORD_WIDTH(CW)) pt_ch ();
    ldf_res_if                     res_ch ();
    ldf_cfg_if #(.COORD_WIDTH(CW)) cfg_ch ();

    lambert_diffuse_factor_unit #(.COORD_WIDTH(CW)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(pt_ch.sink), .o_res(res_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        pt_ch.valid = 0; pt_ch.point_x = 0; pt_ch.point_y = 0; pt_ch.point_z = 0;
        pt_ch.normal_x = 0; pt_ch.normal_y = 0; pt_ch.normal_z = 0;
        res_ch.ready = 0;
        cfg_ch.valid = 0; cfg_ch.index = CFG_LIGHT_X; cfg_ch.data = 0;
        board.light[0] = 0; board.light[1] = 0; board.light[2] = 0;
    end

    // Sink side: random stalls, check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            board.check_result(res_ch.diffuse_factor, res_ch.degenerate);
        res_ch.ready <= snk_quiet ? 1'b1 : ($urandom_range(99) >= 9);
    end

    // Watchdog: count cycles with nothing accepted
    always @(posedge i_clk) begin
        if ((pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("lambert_diffuse_factor_unit_tb: done, errors");
            $finish;
        end
    end

    // Hold valid high; the caller drops it after the last write
    task automatic write_light(logic [CFG_IDX_W-1:0] idx, logic signed [CW-1:0] v);
        cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.set_light(idx, v);
    endtask

    task automatic set_lights(logic signed [CW-1:0] x, y, z);
        write_light(CFG_LIGHT_X, x);
        write_light(CFG_LIGHT_Y, y);
        write_light(CFG_LIGHT_Z, z);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_point(logic signed [CW-1:0] px, py, pz, logic signed [15:0] nx, ny, nz);
        logic signed [CW-1:0] p [3];
        logic signed [15:0] n [3];
        p[0] = px; p[1] = py; p[2] = pz; n[0] = nx; n[1] = ny; n[2] = nz;
        // random gap before the item
        while (!src_quiet && $urandom_range(99) < 9) begin
            pt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_ch.valid <= 1'b1;
        pt_ch.point_x <= px; pt_ch.point_y <= py; pt_ch.point_z <= pz;
        pt_ch.normal_x <= nx; pt_ch.normal_y <= ny; pt_ch.normal_z <= nz;
        do @(posedge i_clk); while (!pt_ch.ready);
        board.note_point(p, n);
    endtask

    task automatic drain();
        pt_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_normal();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 16'($urandom);
        if (k == 1) return 16'sd16384;
        if (k == 2) return -16'sd16384;
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        int k;
        k = $urandom_range(5);
        if (k == 0) return CW'(int'($urandom_range(7)) - 4);
        if (k == 1) return CW'(int'($urandom_range(2047)) - 1024);
        return CW'($urandom);
    endfunction

    task automatic random_phase(int count);
        logic signed [CW-1:0] px, py, pz;
        for (int i = 0; i < count; i++) begin
            src_quiet = (i >= count/3 && i < count/3 + 120);
            snk_quiet = src_quiet;
            // near-light points, with some landing on it exactly
            if ($urandom_range(19) == 0) begin
                px = board.light[0]; py = board.light[1]; pz = board.light[2];
            end else begin
                px = rand_coord(); py = rand_coord(); pz = rand_coord();
                if ($urandom_range(2) == 0) begin
                    px = board.light[0] + px[7:0]; py = board.light[1] - py[5:0];
                end
            end
            send_point(px, py, pz, rand_normal(), rand_normal(), rand_normal());
        end
        src_quiet = 0; snk_quiet = 0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: light at reset origin, degenerate point, facing away, extremes
        send_point(0, 0, 0, 16384, 0, 0);
        send_point(-256, 0, 0, 16384, 0, 0);
        send_point(256, 0, 0, 16384, 0, 0);
        send_point(0, 256, 0, 0, 0, 16384);
        send_point(0, 0, -256, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_point(0, 0, -256, 16'sh8000, 16'sh8000, 16'sh8000);
        send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, -16384, -16384, -16384);
        send_point(16'sh8000, 16'sh8000, 16'sh8000, 16384, 16384, 16384);
        send_point(-1, -1, -1, 9459, 9459, 9459);
        send_point(1, 0, 0, -16384, 0, 0);
        drain();

        set_lights(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_point(16'sh8000, 16'sh8000, 16'sh8000, 16384, 16384, 16384);
        send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 16384, 0, 0);
        send_point(16'sh7fff, 16'sh7fff, 16'sh7ffe, 0, 0, 16384);
        send_point(0, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        drain();

        set_lights(16'sh8000, 16'sh8000, 16'sh8000);
        send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, -16384, -16384, -16384);
        send_point(16'sh8000, 16'sh8000, 16'sh8000, 16384, 0, 0);
        send_point(0, 0, 0, 16'sh8000, 0, 0);
        random_phase(400);
        drain();

        set_lights(0, 0, 0);
        random_phase(400);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            set_lights(rand_coord(), rand_coord(), rand_coord());
            random_phase(340);
            drain();
        end

        if (board.errors == 0)
            $display("lambert_diffuse_factor_unit_tb: done, clean");
        else
            $display("lambert_diffuse_factor_unit_tb: done, errors");
        $finish;
    end
endmodule
